// ===== sv/x86_logic_shift_alu_defines.svh =====
`ifndef X86_LOGIC_SHIFT_ALU_DEFINES_SVH
`define X86_LOGIC_SHIFT_ALU_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define XLSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("x86_logic_shift_alu: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define XLSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("x86_logic_shift_alu: next-cycle check failed");

`endif

// ===== sv/xlsa_pkg.sv =====
package xlsa_pkg;

  localparam logic [3:0] OP_TEST = 4'd0;
  localparam logic [3:0] OP_AND  = 4'd1;
  localparam logic [3:0] OP_XOR  = 4'd2;
  localparam logic [3:0] OP_OR   = 4'd3;
  localparam logic [3:0] OP_SAR  = 4'd4;
  localparam logic [3:0] OP_SHL  = 4'd5;
  localparam logic [3:0] OP_SHR  = 4'd6;
  localparam logic [3:0] OP_NOT  = 4'd7;
  localparam logic [3:0] OP_ROL  = 4'd8;

  localparam logic [1:0] WIDTH_BYTE  = 2'd0;
  localparam logic [1:0] WIDTH_WORD  = 2'd1;
  localparam logic [1:0] WIDTH_DWORD = 2'd2;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] wsel;
  } xlsa_ctl_t;

  typedef struct packed {
    logic result_valid;
    logic zs_update;
    logic co_update;
  } xlsa_upd_t;

  function automatic logic [1:0] norm_width(input logic [1:0] code);
    logic [1:0] w;
    case (code)
      WIDTH_BYTE: w = WIDTH_BYTE;
      WIDTH_WORD: w = WIDTH_WORD;
      default:    w = WIDTH_DWORD;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] width_mask(input logic [1:0] wsel);
    logic [31:0] m;
    case (wsel)
      WIDTH_BYTE: m = 32'h0000_00FF;
      WIDTH_WORD: m = 32'h0000_FFFF;
      default:    m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic top_bit(input logic [31:0] v, input logic [1:0] wsel);
    logic b;
    case (wsel)
      WIDTH_BYTE: b = v[7];
      WIDTH_WORD: b = v[15];
      default:    b = v[31];
    endcase
    return b;
  endfunction

endpackage

// ===== sv/xlsa_exec.sv =====
module xlsa_exec (
  input  xlsa_pkg::xlsa_ctl_t ctl,
  input  logic [31:0]         operand,
  input  logic [31:0]         src,
  output logic [31:0]         result
);
  import xlsa_pkg::*;

  logic [4:0]  cnt;
  logic [63:0] rot_w;
  logic [31:0] raw;

  assign cnt   = src[4:0];
  assign rot_w = {operand, operand} << cnt;

  always_comb begin
    case (ctl.op)
      OP_TEST: raw = operand & src;
      OP_AND:  raw = operand & src;
      OP_XOR:  raw = operand ^ src;
      OP_OR:   raw = operand | src;
      OP_SAR:  raw = $unsigned($signed(operand) >>> cnt);
      OP_SHL:  raw = operand << cnt;
      OP_SHR:  raw = operand >> cnt;
      OP_NOT:  raw = ~operand;
      OP_ROL:  raw = rot_w[63:32];
      default: raw = '0;
    endcase
  end

  assign result = raw & width_mask(ctl.wsel);

endmodule

// ===== sv/x86_logic_shift_alu.sv =====
// Channel | Dir | Fields (lowest bit up)
// s_*     | in  | tdata: dest_value, src_value; tuser: operation, width_code
// m_*     | out | tdata: result, zero_flag, sign_flag, carry_flag, overflow_flag, pad
//         |     | tuser: result_valid, zs_update, co_update
//
// One instruction per cycle unless m_tready stalls; each stage's result is registered.
// Stage 1 decodes width and prepares the operand, stage 2 runs the 32-bit
// barrel shifter/rotator and logic unit, stage 3 forms flags into the output register.
// Reset clears the stage valid bits only.
// A stall on m_tready holds each full stage; bubbles close up behind it.
`include "x86_logic_shift_alu_defines.svh"

module x86_logic_shift_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // dest_value[31:0], src_value[63:32]
  input  logic [5:0]  s_tuser,  // operation[3:0], width_code[5:4]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // result[31:0], zero[32], sign[33], carry[34],
                                // overflow[35], zero pad[39:36]
  output logic [2:0]  m_tuser   // result_valid[0], zs_update[1], co_update[2]
);
  import xlsa_pkg::*;

  logic        adv1, adv2, adv3;
  logic        valid1, valid2;
  xlsa_ctl_t   ctl_in, ctl1, ctl2;
  logic [31:0] d_in, opnd_in;
  logic [31:0] opnd1, src1;
  logic [31:0] res_exec, res2;
  xlsa_upd_t   upd2, upd_out;
  logic [31:0] res_out;
  logic        zero_out, sign_out;

  assign adv3     = !m_tvalid || m_tready;
  assign adv2     = !valid2 || adv3;
  assign adv1     = !valid1 || adv2;
  assign s_tready = adv1;

  assign ctl_in.op   = s_tuser[3:0];
  assign ctl_in.wsel = norm_width(s_tuser[5:4]);
  assign d_in        = s_tdata[31:0] & width_mask(ctl_in.wsel);

  always_comb begin
    opnd_in = d_in;
    if (ctl_in.op == OP_SAR) begin
      case (ctl_in.wsel)
        WIDTH_BYTE: opnd_in = {{24{d_in[7]}}, d_in[7:0]};
        WIDTH_WORD: opnd_in = {{16{d_in[15]}}, d_in[15:0]};
        default:    opnd_in = d_in;
      endcase
    end else if (ctl_in.op == OP_ROL) begin
      case (ctl_in.wsel)
        WIDTH_BYTE: opnd_in = {4{d_in[7:0]}};
        WIDTH_WORD: opnd_in = {2{d_in[15:0]}};
        default:    opnd_in = d_in;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (adv1) begin
      valid1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && s_tvalid) begin
      ctl1  <= ctl_in;
      opnd1 <= opnd_in;
      src1  <= s_tdata[63:32];
    end
  end

  xlsa_exec u_exec (
    .ctl     (ctl1),
    .operand (opnd1),
    .src     (src1),
    .result  (res_exec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (adv2) begin
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && valid1) begin
      ctl2 <= ctl1;
      res2 <= res_exec;
    end
  end

  always_comb begin
    upd2.result_valid = (ctl2.op >= OP_AND) && (ctl2.op <= OP_ROL);
    upd2.zs_update    = ctl2.op <= OP_SHR;
    upd2.co_update    = ctl2.op <= OP_OR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv3) begin
      m_tvalid <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && valid2) begin
      res_out  <= res2;
      upd_out  <= upd2;
      zero_out <= upd2.zs_update && (res2 == 32'd0);
      sign_out <= upd2.zs_update && top_bit(res2, ctl2.wsel);
    end
  end

  assign m_tdata = {4'b0000, 1'b0, 1'b0, sign_out, zero_out, res_out};
  assign m_tuser = {upd_out.co_update, upd_out.zs_update, upd_out.result_valid};

  `XLSA_ASSERT_NOW(a_full_stall_blocks_input, valid1 && valid2 && m_tvalid && !m_tready, !s_tready)
  `XLSA_ASSERT_NOW(a_flags_gated, m_tvalid && !m_tuser[1], !m_tdata[32] && !m_tdata[33])
  `XLSA_ASSERT_NOW(a_co_implies_zs, m_tvalid && m_tuser[2], m_tuser[1])
  `XLSA_ASSERT_NEXT(a_stage2_drains, valid2 && adv3, m_tvalid)

endmodule
